/* hdl/mrif_pkg.sv */
// Shared types, constants and register codes of the mixed-radix index flattener.
package mrif_pkg;

    localparam int MAX_DIMS      = 4;
    localparam int COORD_BITS    = 12;
    localparam int FLAT_BITS     = 48;
    localparam int TOTAL_BITS    = FLAT_BITS + 1;
    localparam int RANGE_BITS    = COORD_BITS + 1;
    localparam int DIMS_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = RANGE_BITS;
    localparam int PROD_BITS     = FLAT_BITS + COORD_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DIMS   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE0 = 3'd1;

    // request types
    localparam logic REQ_FLATTEN = 1'b0;
    localparam logic REQ_EXPAND  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COORD = 2'd1;
    localparam logic [1:0] ST_FLAT  = 2'd2;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] coord_in0;
        logic [COORD_BITS-1:0] coord_in1;
        logic [COORD_BITS-1:0] coord_in2;
        logic [COORD_BITS-1:0] coord_in3;
        logic [FLAT_BITS-1:0]  flat_in;
    } t_req;

    typedef struct packed {
        logic [FLAT_BITS-1:0]  flat_out;
        logic [COORD_BITS-1:0] coord_out0;
        logic [COORD_BITS-1:0] coord_out1;
        logic [COORD_BITS-1:0] coord_out2;
        logic [COORD_BITS-1:0] coord_out3;
        logic [TOTAL_BITS-1:0] total_size;
        logic [1:0]            status;
        logic [1:0]            bad_dim;
    } t_res;

    // one transaction in flight through the pipeline
    typedef struct packed {
        logic                                  req_type;
        logic [DIMS_BITS-1:0]                  dims;
        logic [MAX_DIMS-1:0][RANGE_BITS-1:0]   range;
        logic [MAX_DIMS-1:0][COORD_BITS-1:0]   coord;
        logic [FLAT_BITS-1:0]                  rem;
        logic [MAX_DIMS-1:0][FLAT_BITS-1:0]    stride;
        logic [TOTAL_BITS-1:0]                 total;
        logic [MAX_DIMS-1:0][COORD_BITS-1:0]   quot;
        logic [MAX_DIMS-1:0][FLAT_BITS-1:0]    prod;
        logic [MAX_DIMS-1:0]                   bad;
        logic                                  flat_err;
    } t_stage;

endpackage

/* hdl/mrif_stride.sv */
// One stride stage: records the stride of its dimension and extends the running product.
module mrif_stride #(
    parameter int DIM = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mrif_pkg::t_stage i_stage,
    output logic            o_valid,
    output mrif_pkg::t_stage o_stage
);

    logic             r_valid;
    mrif_pkg::t_stage r_stage;
    mrif_pkg::t_stage n_stage;

    always_comb begin
        n_stage = i_stage;
        if (mrif_pkg::DIMS_BITS'(DIM) < i_stage.dims) begin
            n_stage.stride[DIM] = i_stage.total[mrif_pkg::FLAT_BITS-1:0];
            n_stage.total = mrif_pkg::TOTAL_BITS'(i_stage.total *
                            mrif_pkg::TOTAL_BITS'(i_stage.range[DIM]));
        end else begin
            n_stage.stride[DIM] = mrif_pkg::FLAT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* hdl/mrif_lane.sv */
// Lane of one dimension: coordinate product and range check, then its quotient bits.
module mrif_lane #(
    parameter int DIM = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mrif_pkg::t_stage i_stage,
    output logic            o_valid,
    output mrif_pkg::t_stage o_stage
);

    localparam int NSTEP = (DIM == 0) ? 1 : mrif_pkg::COORD_BITS;

    logic [NSTEP-1:0]            r_valid;
    mrif_pkg::t_stage [NSTEP-1:0] r_stage;
    mrif_pkg::t_stage [NSTEP-1:0] n_stage;

    always_comb begin
        logic                           act;
        logic [mrif_pkg::PROD_BITS-1:0] trial;
        logic [mrif_pkg::PROD_BITS-1:0] p;
        int                             b;
        n_stage[0] = i_stage;
        for (int k = 1; k < NSTEP; k++) begin
            n_stage[k] = r_stage[k-1];
        end
        for (int k = 0; k < NSTEP; k++) begin
            act = mrif_pkg::DIMS_BITS'(DIM) < n_stage[k].dims;
            trial = '0;
            p = '0;
            b = mrif_pkg::COORD_BITS - 1 - k;
            if (k == 0) begin
                p = mrif_pkg::PROD_BITS'(n_stage[k].coord[DIM]) *
                    mrif_pkg::PROD_BITS'(n_stage[k].stride[DIM]);
                n_stage[k].prod[DIM] = act ? p[mrif_pkg::FLAT_BITS-1:0] : '0;
                n_stage[k].bad[DIM]  = act && (mrif_pkg::RANGE_BITS'(n_stage[k].coord[DIM])
                                              >= n_stage[k].range[DIM]);
                if (DIM == mrif_pkg::MAX_DIMS - 1) begin
                    n_stage[k].flat_err = mrif_pkg::TOTAL_BITS'(n_stage[k].rem)
                                          >= n_stage[k].total;
                end
            end
            if (DIM == 0) begin
                // what is left after the upper dimensions is coordinate zero
                n_stage[k].quot[0] = n_stage[k].rem[mrif_pkg::COORD_BITS-1:0];
            end else begin
                trial = mrif_pkg::PROD_BITS'(n_stage[k].stride[DIM]) << b;
                if (act && (mrif_pkg::PROD_BITS'(n_stage[k].rem) >= trial)) begin
                    n_stage[k].rem = n_stage[k].rem - trial[mrif_pkg::FLAT_BITS-1:0];
                    n_stage[k].quot[DIM][b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= NSTEP'({r_valid, i_valid});
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid[NSTEP-1];
    assign o_stage = r_stage[NSTEP-1];

endmodule

/* hdl/mrif_merge.sv */
// Merging stage: sums the lane products, picks the failing lane and forms the result.
module mrif_merge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mrif_pkg::t_stage i_stage,
    output logic            o_done,
    output mrif_pkg::t_res   o_result
);

    logic           r_done;
    mrif_pkg::t_res r_result;
    mrif_pkg::t_res n_result;

    always_comb begin
        logic [mrif_pkg::FLAT_BITS-1:0] sum;
        logic [1:0]                     bad;
        sum = '0;
        bad = '0;
        for (int i = 0; i < mrif_pkg::MAX_DIMS; i++) begin
            sum = sum + i_stage.prod[i];
        end
        // lowest failing dimension wins
        for (int i = mrif_pkg::MAX_DIMS - 1; i >= 0; i--) begin
            if (i_stage.bad[i]) begin
                bad = 2'(i);
            end
        end
        n_result = '0;
        n_result.total_size = i_stage.total;
        if (i_stage.req_type == mrif_pkg::REQ_FLATTEN) begin
            if (|i_stage.bad) begin
                n_result.status  = mrif_pkg::ST_COORD;
                n_result.bad_dim = bad;
            end else begin
                n_result.flat_out = sum;
            end
        end else if (i_stage.flat_err) begin
            n_result.status = mrif_pkg::ST_FLAT;
        end else begin
            n_result.coord_out0 = i_stage.quot[0];
            n_result.coord_out1 = i_stage.quot[1];
            n_result.coord_out2 = i_stage.quot[2];
            n_result.coord_out3 = i_stage.quot[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* hdl/mixed_radix_index_flattener_unit.sv */
// Top level of the mixed-radix index flattener: configuration, capture and pipeline.
//
//  channel   signals                            direction  handshake
//  request   start, busy, i_req                 in         start && !busy
//  result    o_done, o_result                   out        o_done strobe, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data    in         i_cfg_we
//
// One transaction is taken every cycle; busy is never raised.
// The pipeline length is set by the quotient chain, after the capture register and the
// stride stages: one quotient bit per stage from the slowest dimension down.
// Strides and total size are rebuilt for each transaction in the stride stages.
// Reset is synchronous; it clears the valid chain and loads four dimensions of range one.
// The receiver takes every result in the cycle it is shown.
module mixed_radix_index_flattener_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  mrif_pkg::t_req                         i_req,
    output logic                                  o_done,
    output mrif_pkg::t_res                         o_result,
    input  logic                                  i_cfg_we,
    input  logic [mrif_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [mrif_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int ND = mrif_pkg::MAX_DIMS;

    logic [mrif_pkg::DIMS_BITS-1:0]             r_dims;
    logic [ND-1:0][mrif_pkg::RANGE_BITS-1:0]    r_range;
    logic                                       r_valid;
    mrif_pkg::t_stage                            r_stage;
    mrif_pkg::t_stage                            n_stage;

    logic             w_valid [0:2*ND];
    mrif_pkg::t_stage w_stage [0:2*ND];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= mrif_pkg::DIMS_BITS'(ND);
            r_range <= {ND{mrif_pkg::RANGE_BITS'(1)}};
        end else if (i_cfg_we) begin
            if (i_cfg_idx == mrif_pkg::REG_DIMS) begin
                r_dims <= i_cfg_data[mrif_pkg::DIMS_BITS-1:0];
            end
            for (int i = 0; i < ND; i++) begin
                if (i_cfg_idx == mrif_pkg::REG_RANGE0 + mrif_pkg::CFG_IDX_BITS'(i)) begin
                    r_range[i] <= i_cfg_data;
                end
            end
        end
    end

    // clamp the registers and load the transaction
    always_comb begin
        n_stage = '0;
        n_stage.req_type = i_req.req_type;
        if (r_dims == '0) begin
            n_stage.dims = mrif_pkg::DIMS_BITS'(1);
        end else if (r_dims > mrif_pkg::DIMS_BITS'(ND)) begin
            n_stage.dims = mrif_pkg::DIMS_BITS'(ND);
        end else begin
            n_stage.dims = r_dims;
        end
        for (int i = 0; i < ND; i++) begin
            if (r_range[i] == '0) begin
                n_stage.range[i] = mrif_pkg::RANGE_BITS'(1);
            end else if (r_range[i] > (mrif_pkg::RANGE_BITS'(1) << mrif_pkg::COORD_BITS)) begin
                n_stage.range[i] = mrif_pkg::RANGE_BITS'(1) << mrif_pkg::COORD_BITS;
            end else begin
                n_stage.range[i] = r_range[i];
            end
        end
        n_stage.coord[0] = i_req.coord_in0;
        n_stage.coord[1] = i_req.coord_in1;
        n_stage.coord[2] = i_req.coord_in2;
        n_stage.coord[3] = i_req.coord_in3;
        n_stage.rem      = i_req.flat_in;
        n_stage.total    = mrif_pkg::TOTAL_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign w_valid[0] = r_valid;
    assign w_stage[0] = r_stage;

    for (genvar g = 0; g < ND; g++) begin : g_stride
        mrif_stride #(.DIM(g)) u_stride (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    for (genvar g = 0; g < ND; g++) begin : g_lane
        mrif_lane #(.DIM(ND-1-g)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[ND+g]),
            .i_stage (w_stage[ND+g]),
            .o_valid (w_valid[ND+g+1]),
            .o_stage (w_stage[ND+g+1])
        );
    end

    mrif_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[2*ND]),
        .i_stage  (w_stage[2*ND]),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_flat_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == mrif_pkg::ST_FLAT |->
        o_result.flat_out == '0 && o_result.coord_out0 == '0 && o_result.coord_out1 == '0 &&
        o_result.coord_out2 == '0 && o_result.coord_out3 == '0 && o_result.bad_dim == '0)
        else $error("flat index error result carries data");

    a_coord_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == mrif_pkg::ST_COORD |-> o_result.flat_out == '0)
        else $error("coordinate error result carries a flat index");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.status != 2'd3)
        else $error("undefined status code");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.total_size != '0)
        else $error("total size of zero");

endmodule
